@@ hdl/i8080_pkg.sv @@
package i8080_pkg;

    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int SEL_W      = 3;
    localparam int OPER_W     = 2;
    localparam int GPR_NUM    = 6;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 8;

    localparam logic [OPER_W-1:0] OP_MEM_WR = 2'd0;
    localparam logic [OPER_W-1:0] OP_EXEC   = 2'd1;
    localparam logic [OPER_W-1:0] OP_REG_WR = 2'd2;

    localparam logic [SEL_W-1:0] REG_H = 3'd4;
    localparam logic [SEL_W-1:0] REG_L = 3'd5;
    localparam logic [SEL_W-1:0] SRC_M = 3'd6;
    localparam logic [SEL_W-1:0] SRC_A = 3'd7;

    localparam logic [2:0] GRP_ADD = 3'd0;
    localparam logic [2:0] GRP_ADC = 3'd1;
    localparam logic [2:0] GRP_SUB = 3'd2;
    localparam logic [2:0] GRP_SBB = 3'd3;
    localparam logic [2:0] GRP_ANA = 3'd4;
    localparam logic [2:0] GRP_XRA = 3'd5;
    localparam logic [2:0] GRP_ORA = 3'd6;

    localparam logic [BYTE_W-1:0] OPC_NOP    = 8'h00;
    localparam logic [BYTE_W-1:0] OPC_ALU_LO = 8'h80;
    localparam logic [BYTE_W-1:0] OPC_ALU_HI = 8'hB7;

    typedef struct packed {
        logic p;
        logic s;
        logic z;
        logic ac;
        logic cy;
    } flags_t;

endpackage

@@ hdl/i8080_ram.sv @@
module i8080_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/i8080_alu.sv @@
module i8080_alu
    import i8080_pkg::*;
(
    input  logic [2:0]        grp,
    input  logic [BYTE_W-1:0] a,
    input  logic [BYTE_W-1:0] v,
    input  logic              cin,
    output logic [BYTE_W-1:0] res,
    output flags_t            flags
);

    logic              sub;
    logic              c;
    logic [BYTE_W-1:0] vx;
    logic [BYTE_W:0]   full;
    logic [4:0]        low;
    logic              cy;
    logic              ac;

    // subtract as a + ~v + ~borrow, carry out inverted into borrow
    assign sub  = (grp == GRP_SUB) || (grp == GRP_SBB);
    assign c    = ((grp == GRP_ADC) || (grp == GRP_SBB)) ? cin : 1'b0;
    assign vx   = sub ? ~v : v;
    assign full = {1'b0, a} + {1'b0, vx} + {8'b0, c ^ sub};
    assign low  = {1'b0, a[3:0]} + {1'b0, vx[3:0]} + {4'b0, c ^ sub};

    always_comb begin
        unique case (grp)
            GRP_ADD, GRP_ADC, GRP_SUB, GRP_SBB: begin
                res = full[BYTE_W-1:0];
                cy  = full[BYTE_W] ^ sub;
                ac  = low[4] ^ sub;
            end
            GRP_ANA: begin
                res = a & v;
                cy  = 1'b0;
                ac  = 1'b1;
            end
            GRP_XRA: begin
                res = a ^ v;
                cy  = 1'b0;
                ac  = 1'b0;
            end
            default: begin
                res = a | v;
                cy  = 1'b0;
                ac  = 1'b0;
            end
        endcase
    end

    assign flags.cy = cy;
    assign flags.ac = ac;
    assign flags.z  = (res == '0);
    assign flags.s  = res[BYTE_W-1];
    assign flags.p  = ~^res;

endmodule

@@ hdl/i8080_alu_instruction_core_top.sv @@
// Partial 8080 core: one transaction writes a memory byte, writes a register or
// executes the instruction at PC (NOP or the ADD..ORA groups); every transaction
// returns A, the flags, PC, the executed opcode and a status bit. After reset
// all MEM_DEPTH bytes of memory are swept to zero, one byte per cycle, with
// s_tready low. The block takes one transaction at a time through a small
// sequencer around a synchronous memory and one shared ALU: a register write
// goes from idle straight to done, a memory write through a write state, an
// execute through fetch and opcode states, plus operand-read and execute
// states for [HL]; memory reads are registered. For a MEM_DEPTH that is not a
// power of two, addresses are reduced modulo it, one compare-subtract per cycle.
module i8080_alu_instruction_core_top
    import i8080_pkg::*;
#(
    parameter int MEM_DEPTH = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // address, data_byte, reg_select
    input  logic [IN_USER_W-1:0]  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // acc_value, carry_flag, aux_carry_flag, zero_flag, sign_flag,
    // parity_flag, program_counter, fetched_opcode
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser    // status
);

    localparam int AW        = $clog2(MEM_DEPTH);
    localparam bit NEED_MOD  = (MEM_DEPTH != (1 << AW));
    localparam int STEP_MAX  = ADDR_W - AW;
    localparam int STEP_W    = (STEP_MAX > 0) ? $clog2(STEP_MAX + 1) : 1;
    localparam logic [STEP_W-1:0] STEP_INIT = STEP_W'(STEP_MAX);
    localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(MEM_DEPTH);
    localparam logic [AW-1:0]     CLR_LAST  = AW'(MEM_DEPTH - 1);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_REDUCE = 4'd2;
    localparam logic [3:0] ST_MEMW   = 4'd3;
    localparam logic [3:0] ST_FETCH  = 4'd4;
    localparam logic [3:0] ST_OPCODE = 4'd5;
    localparam logic [3:0] ST_OPRD   = 4'd6;
    localparam logic [3:0] ST_EXEC   = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]        state_reg,  state_next;
    logic [3:0]        target_reg, target_next;
    logic [STEP_W-1:0] step_reg,   step_next;
    logic [ADDR_W-1:0] addr_reg,   addr_next;
    logic [BYTE_W-1:0] data_reg,   data_next;
    logic [AW-1:0]     clr_reg,    clr_next;
    logic [ADDR_W-1:0] pc_reg,     pc_next;
    logic [BYTE_W-1:0] acc_reg,    acc_next;
    flags_t            flags_reg,  flags_next;
    logic [BYTE_W-1:0] gpr_reg [GPR_NUM];
    logic [BYTE_W-1:0] gpr_next [GPR_NUM];
    logic [BYTE_W-1:0] opcode_reg, opcode_next;
    logic              status_reg, status_next;

    logic                  m_tvalid_reg,   m_tvalid_next;
    logic [OUT_DATA_W-1:0] out_data_reg,   out_data_next;
    logic                  out_status_reg, out_status_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    logic [BYTE_W-1:0] alu_op;
    logic [SEL_W-1:0]  src;
    logic [BYTE_W-1:0] reg_operand;
    logic [BYTE_W-1:0] alu_v;
    logic [BYTE_W-1:0] alu_res;
    flags_t            alu_flags;
    logic              impl;
    logic [ADDR_W:0]   mod_limit;

    logic [OPER_W-1:0] in_oper;
    logic [ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0] in_data;
    logic [SEL_W-1:0]  in_sel;

    assign in_oper = s_tuser[OPER_W-1:0];
    assign in_addr = s_tdata[ADDR_W-1:0];
    assign in_data = s_tdata[ADDR_W +: BYTE_W];
    assign in_sel  = s_tdata[ADDR_W + BYTE_W +: SEL_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {{(OUT_USER_W - 1){1'b0}}, out_status_reg};

    i8080_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign alu_op = (state_reg == ST_OPCODE) ? ram_rdata : opcode_reg;
    assign src    = alu_op[SEL_W-1:0];
    assign impl   = (alu_op >= OPC_ALU_LO) && (alu_op <= OPC_ALU_HI);

    always_comb begin
        unique case (src)
            SRC_A, SRC_M: reg_operand = acc_reg;
            default:      reg_operand = gpr_reg[src];
        endcase
    end

    assign alu_v = (state_reg == ST_EXEC) ? ram_rdata : reg_operand;

    i8080_alu u_alu (
        .grp   (alu_op[5:3]),
        .a     (acc_reg),
        .v     (alu_v),
        .cin   (flags_reg.cy),
        .res   (alu_res),
        .flags (alu_flags)
    );

    assign mod_limit = DEPTH_EXT << step_reg;

    always_comb begin
        state_next      = state_reg;
        target_next     = target_reg;
        step_next       = step_reg;
        addr_next       = addr_reg;
        data_next       = data_reg;
        clr_next        = clr_reg;
        pc_next         = pc_reg;
        acc_next        = acc_reg;
        flags_next      = flags_reg;
        gpr_next        = gpr_reg;
        opcode_next     = opcode_reg;
        status_next     = status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg[AW-1:0];
        ram_wdata       = data_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    opcode_next = '0;
                    status_next = 1'b0;
                    step_next   = STEP_INIT;
                    unique case (in_oper)
                        OP_MEM_WR: begin
                            addr_next   = in_addr;
                            data_next   = in_data;
                            target_next = ST_MEMW;
                            state_next  = NEED_MOD ? ST_REDUCE : ST_MEMW;
                        end
                        OP_EXEC: begin
                            addr_next   = pc_reg;
                            pc_next     = pc_reg + ADDR_W'(1);
                            target_next = ST_FETCH;
                            state_next  = NEED_MOD ? ST_REDUCE : ST_FETCH;
                        end
                        OP_REG_WR: begin
                            if (in_sel == SRC_A) begin
                                acc_next = in_data;
                            end else if (in_sel != SRC_M) begin
                                gpr_next[in_sel] = in_data;
                            end
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_REDUCE: begin
                if ({1'b0, addr_reg} >= mod_limit) begin
                    addr_next = addr_reg - mod_limit[ADDR_W-1:0];
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = target_reg;
                end
            end
            ST_MEMW: begin
                ram_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_FETCH: begin
                state_next = ST_OPCODE;
            end
            ST_OPCODE: begin
                opcode_next = ram_rdata;
                state_next  = ST_DONE;
                if (ram_rdata != OPC_NOP) begin
                    if (!impl) begin
                        status_next = 1'b1;
                    end else if (src == SRC_M) begin
                        addr_next   = {gpr_reg[REG_H], gpr_reg[REG_L]};
                        step_next   = STEP_INIT;
                        target_next = ST_OPRD;
                        state_next  = NEED_MOD ? ST_REDUCE : ST_OPRD;
                    end else begin
                        acc_next   = alu_res;
                        flags_next = alu_flags;
                    end
                end
            end
            ST_OPRD: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                acc_next   = alu_res;
                flags_next = alu_flags;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    out_data_next   = OUT_DATA_W'({opcode_reg, pc_reg, flags_reg.p,
                                      flags_reg.s, flags_reg.z, flags_reg.ac,
                                      flags_reg.cy, acc_reg});
                    out_status_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            pc_reg       <= '0;
            acc_reg      <= '0;
            flags_reg    <= '0;
            gpr_reg      <= '{default: '0};
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            pc_reg       <= pc_next;
            acc_reg      <= acc_next;
            flags_reg    <= flags_next;
            gpr_reg      <= gpr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg     <= target_next;
        step_reg       <= step_next;
        addr_reg       <= addr_next;
        data_reg       <= data_next;
        opcode_reg     <= opcode_next;
        status_reg     <= status_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

`ifndef NO_ASSERTIONS
    a_no_result_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_tvalid_reg
    ) else $error("result presented during memory clear");

    a_result_from_done: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE)
    ) else $error("result loaded outside completion state");

    a_status_only_unimplemented: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_status_reg) |->
            ((out_data_reg[36:29] != OPC_NOP) &&
             ((out_data_reg[36:29] < OPC_ALU_LO) || (out_data_reg[36:29] > OPC_ALU_HI)))
    ) else $error("unimplemented status on an implemented opcode");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import i8080_pkg::*;

    localparam int MEM_DEPTH   = 65536;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 600;

    localparam logic [OPER_W-1:0] OP_IGNORED = 2'd3;
    localparam logic [SEL_W-1:0]  REG_B      = 3'd0;
    localparam logic [SEL_W-1:0]  REG_C      = 3'd1;
    localparam logic [SEL_W-1:0]  REG_D      = 3'd2;
    localparam logic [SEL_W-1:0]  REG_E      = 3'd3;

    typedef struct {
        logic [BYTE_W-1:0] acc;
        logic              cy;
        logic              ac;
        logic              z;
        logic              s;
        logic              p;
        logic [ADDR_W-1:0] pc;
        logic [BYTE_W-1:0] opcode;
        logic              status;
    } core_result_t;

    class cpu_shadow;
        bit [BYTE_W-1:0] mem [MEM_DEPTH];
        bit [BYTE_W-1:0] gpr [GPR_NUM];
        bit [BYTE_W-1:0] acc;
        bit [ADDR_W-1:0] pc;
        flags_t          flg;
        core_result_t    pending_states [$];
        int              errors;

        function new();
            foreach (mem[i]) mem[i] = '0;
            foreach (gpr[i]) gpr[i] = '0;
            acc    = '0;
            pc     = '0;
            flg    = '0;
            errors = 0;
        endfunction

        function void run_alu(logic [BYTE_W-1:0] opc);
            int   a;
            int   v;
            int   cin;
            int   res;
            logic cy;
            logic ac;
            a   = acc;
            cin = flg.cy;
            case (opc[2:0])
                SRC_M:   v = mem[{gpr[REG_H], gpr[REG_L]} % MEM_DEPTH];
                SRC_A:   v = acc;
                default: v = gpr[opc[2:0]];
            endcase
            case (opc[5:3])
                GRP_ADD: begin
                    res = a + v;
                    cy  = res > 255;
                    ac  = ((a & 15) + (v & 15)) > 15;
                end
                GRP_ADC: begin
                    res = a + v + cin;
                    cy  = res > 255;
                    ac  = ((a & 15) + (v & 15) + cin) > 15;
                end
                GRP_SUB: begin
                    res = a - v;
                    cy  = a < v;
                    ac  = (a & 15) < (v & 15);
                end
                GRP_SBB: begin
                    res = a - v - cin;
                    cy  = a < v + cin;
                    ac  = (a & 15) < (v & 15) + cin;
                end
                GRP_ANA: begin
                    res = a & v;
                    cy  = 1'b0;
                    ac  = 1'b1;
                end
                GRP_XRA: begin
                    res = a ^ v;
                    cy  = 1'b0;
                    ac  = 1'b0;
                end
                default: begin
                    res = a | v;
                    cy  = 1'b0;
                    ac  = 1'b0;
                end
            endcase
            acc    = res[BYTE_W-1:0];
            flg.cy = cy;
            flg.ac = ac;
            flg.z  = (acc == '0);
            flg.s  = acc[BYTE_W-1];
            flg.p  = ~^acc;
        endfunction

        function void apply_item(logic [OPER_W-1:0] op, logic [ADDR_W-1:0] addr,
                                 logic [BYTE_W-1:0] dat, logic [SEL_W-1:0] sel);
            core_result_t r;
            r.opcode = '0;
            r.status = 1'b0;
            case (op)
                OP_MEM_WR: mem[addr % MEM_DEPTH] = dat;
                OP_EXEC: begin
                    r.opcode = mem[pc % MEM_DEPTH];
                    pc       = pc + 16'd1;
                    if (r.opcode >= OPC_ALU_LO && r.opcode <= OPC_ALU_HI) begin
                        run_alu(r.opcode);
                    end else if (r.opcode != OPC_NOP) begin
                        r.status = 1'b1;
                    end
                end
                OP_REG_WR: begin
                    if (sel == SRC_A) begin
                        acc = dat;
                    end else if (sel != SRC_M) begin
                        gpr[sel] = dat;
                    end
                end
                default: ;
            endcase
            r.acc = acc;
            r.cy  = flg.cy;
            r.ac  = flg.ac;
            r.z   = flg.z;
            r.s   = flg.s;
            r.p   = flg.p;
            r.pc  = pc;
            pending_states.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] td, logic [OUT_USER_W-1:0] tu);
            core_result_t want;
            if (pending_states.size() == 0) begin
                $error("result transaction with no expectation pending");
                errors++;
                return;
            end
            want = pending_states.pop_front();
            compare_field("acc_value",       16'(want.acc),    16'(td[7:0]));
            compare_field("carry_flag",      16'(want.cy),     16'(td[8]));
            compare_field("aux_carry_flag",  16'(want.ac),     16'(td[9]));
            compare_field("zero_flag",       16'(want.z),      16'(td[10]));
            compare_field("sign_flag",       16'(want.s),      16'(td[11]));
            compare_field("parity_flag",     16'(want.p),      16'(td[12]));
            compare_field("program_counter", want.pc,          td[28:13]);
            compare_field("fetched_opcode",  16'(want.opcode), 16'(td[36:29]));
            compare_field("status",          16'(want.status), 16'(tu[0]));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // address, data_byte, reg_select
    logic [IN_USER_W-1:0]  s_tuser;   // operation
    logic                  m_tvalid;
    logic                  m_tready;
    // acc_value, carry_flag, aux_carry_flag, zero_flag, sign_flag,
    // parity_flag, program_counter, fetched_opcode
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;   // status

    cpu_shadow shadow;
    int        snd_idle_pct;
    int        rcv_stall_pct;
    int        items_sent;
    int        cycle_count;

    i8080_alu_instruction_core_top #(
        .MEM_DEPTH(MEM_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            shadow.check_result(m_tdata, m_tuser);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 11))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h0F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_txn(input logic [OPER_W-1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] dat, input logic [SEL_W-1:0] sel);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, sel, dat, addr};
        s_tuser  <= {6'b0, op};
        do @(posedge aclk); while (!s_tready);
        shadow.apply_item(op, addr, dat, sel);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (shadow.pending_states.size() != 0) @(posedge aclk);
    endtask

    task automatic random_step();
        int unsigned       pick;
        logic [BYTE_W-1:0] opc;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if ($urandom_range(0, 9) < 9) begin
                opc = {2'b10, 3'($urandom_range(0, 6)), 3'($urandom_range(0, 7))};
            end else begin
                opc = 8'($urandom);
            end
            if (opc[2:0] == SRC_M && $urandom_range(0, 1) == 1) begin
                send_txn(OP_REG_WR, 16'($urandom), rand_byte(), REG_H);
                send_txn(OP_REG_WR, 16'($urandom), rand_byte(), REG_L);
                send_txn(OP_MEM_WR, {shadow.gpr[REG_H], shadow.gpr[REG_L]}, rand_byte(),
                         3'($urandom));
            end
            send_txn(OP_MEM_WR, shadow.pc, opc, 3'($urandom));
            send_txn(OP_EXEC, 16'($urandom), rand_byte(), 3'($urandom));
        end else if (pick < 60) begin
            send_txn(OP_EXEC, 16'($urandom), rand_byte(), 3'($urandom));
        end else if (pick < 78) begin
            send_txn(OP_REG_WR, 16'($urandom), rand_byte(), 3'($urandom));
        end else if (pick < 94) begin
            send_txn(OP_MEM_WR, 16'($urandom), rand_byte(), 3'($urandom));
        end else begin
            send_txn(OP_IGNORED, 16'($urandom), rand_byte(), 3'($urandom));
        end
    endtask

    task automatic random_phase(input int snd_pct, input int rcv_pct);
        int target;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        target        = items_sent + PHASE_ITEMS;
        while (items_sent < target) random_step();
    endtask

    initial begin
        logic [BYTE_W-1:0] program_bytes [8];
        shadow        = new();
        snd_idle_pct  = 22;
        rcv_stall_pct = 83;
        items_sent    = 0;
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: register writes, operand in memory, one opcode of every group
        program_bytes = '{{2'b10, GRP_ADD, REG_B}, {2'b10, GRP_ADC, REG_C},
                          {2'b10, GRP_SUB, REG_D}, {2'b10, GRP_SBB, SRC_M},
                          {2'b10, GRP_ANA, REG_E}, {2'b10, GRP_XRA, REG_L},
                          {2'b10, GRP_ORA, SRC_A}, OPC_NOP};
        send_txn(OP_IGNORED, 16'hFFFF, 8'hFF, 3'd7);
        send_txn(OP_REG_WR, 16'h0000, 8'hFF, REG_B);
        send_txn(OP_REG_WR, 16'h0000, 8'h00, REG_C);
        send_txn(OP_REG_WR, 16'h0000, 8'h0F, REG_D);
        send_txn(OP_REG_WR, 16'h0000, 8'h80, REG_E);
        send_txn(OP_REG_WR, 16'h0000, 8'hFF, REG_H);
        send_txn(OP_REG_WR, 16'h0000, 8'hFF, REG_L);
        send_txn(OP_REG_WR, 16'h0000, 8'h55, SRC_M);
        send_txn(OP_REG_WR, 16'h0000, 8'h01, SRC_A);
        send_txn(OP_MEM_WR, 16'hFFFF, 8'h5A, REG_B);
        for (int i = 0; i < 8; i++) begin
            send_txn(OP_MEM_WR, 16'(i), program_bytes[i], REG_B);
            send_txn(OP_EXEC, 16'h0000, 8'h00, REG_B);
        end
        send_txn(OP_MEM_WR, shadow.pc, OPC_ALU_HI + 8'd1, REG_B);
        send_txn(OP_EXEC, 16'h0000, 8'h00, REG_B);

        random_phase(22, 83);
        drain();
        random_phase(83, 22);
        drain();
        random_phase(0, 0);
        drain();
        repeat (20) @(posedge aclk);

        if (shadow.errors == 0 && shadow.pending_states.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/i8080_pkg.sv
hdl/i8080_ram.sv
hdl/i8080_alu.sv
hdl/i8080_alu_instruction_core_top.sv
tb/tb.sv
